// ===== rtl/rtewma_pkg.sv =====
// ----------------------------------------------------------------------------
// rtewma_pkg
// Shared types and codes for the route table with smoothed link metrics.
// ----------------------------------------------------------------------------
package rtewma_pkg;

   localparam int CMD_W     = 2;
   localparam int KEY_W     = 64;
   localparam int SESSION_W = 64;
   localparam int LOSS_W    = 16;
   localparam int RTT_W     = 40;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 7;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_REFRESHED = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_DONE      = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_BAD_KEY   = 3'd5;

   typedef struct packed {
      logic [SESSION_W-1:0] session;
      logic [LOSS_W-1:0]    loss;
      logic [RTT_W-1:0]     rtt;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_READ,
      S_MODIFY,
      S_DONE
   } state_type;

endpackage

// ===== rtl/route_table_with_ewma_metrics.sv =====
// ----------------------------------------------------------------------------
// route_table_with_ewma_metrics
// Node-keyed route table with add, remove, find and metric smoothing.
// ----------------------------------------------------------------------------
// channel | ports  | direction | beat
// --------+--------+-----------+------------------------------------------
// request | req_*  | in        | command, node key, session, loss, rtt
// result  | rsp_*  | out       | status, hit fields, entry count
//
// A command runs from accept to result in these steps: the key memory is
// scanned one entry per cycle, then a read and a write-back pass follow.
// A hit ends the scan early; a bad-key add skips it.
// Synchronous reset empties the table; no clearing pass is needed.
// A stalled result holds in the output register; the next request is taken
// once the command in flight has handed its result to that register.
// ----------------------------------------------------------------------------
module route_table_with_ewma_metrics
   import rtewma_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [KEY_W-1:0]     req_node_key,
   input  logic [SESSION_W-1:0] req_session_value,
   input  logic [LOSS_W-1:0]    req_loss_sample,
   input  logic [RTT_W-1:0]     req_rtt_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [SESSION_W-1:0] rsp_hit_session,
   output logic [LOSS_W-1:0]    rsp_hit_loss,
   output logic [RTT_W-1:0]     rsp_hit_rtt,
   output logic [COUNT_W-1:0]   rsp_entry_count
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   function automatic logic [LOSS_W-1:0] blend_loss(input logic [LOSS_W-1:0] old,
                                                    input logic [LOSS_W-1:0] smp);
      logic [LOSS_W+3:0] sum;
      sum = ({4'b0, old} << 3) - {4'b0, old} + {4'b0, smp};
      return (old == '0) ? smp : sum[LOSS_W+2:3];
   endfunction

   function automatic logic [RTT_W-1:0] blend_rtt(input logic [RTT_W-1:0] old,
                                                  input logic [RTT_W-1:0] smp);
      logic [RTT_W+3:0] sum;
      sum = ({4'b0, old} << 3) - {4'b0, old} + {4'b0, smp};
      return (old == '0) ? smp : sum[RTT_W+2:3];
   endfunction

   logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
   entry_type        data_mem [TABLE_DEPTH];

   state_type state_ff, state_in;

   logic [CMD_W-1:0]     cmd_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [SESSION_W-1:0] sess_ff;
   logic [LOSS_W-1:0]    loss_ff;
   logic [RTT_W-1:0]     rtt_ff;

   logic [CNT_W-1:0] count_ff, count_in, count_dec;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic             found_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   logic [IDX_W-1:0] last_idx;
   logic             scan_issue, hit, full;

   logic [STATUS_W-1:0]  res_status_ff;
   logic [SESSION_W-1:0] res_sess_ff;
   logic [LOSS_W-1:0]    res_loss_ff;
   logic [RTT_W-1:0]     res_rtt_ff;

   logic [KEY_W-1:0] key_q;
   entry_type        data_q;
   logic [IDX_W-1:0] key_rd_addr, data_rd_addr;
   logic             key_we, data_we;
   logic [IDX_W-1:0] key_wa, data_wa;
   logic [KEY_W-1:0] key_wd;
   entry_type        data_wd;

   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [SESSION_W-1:0] rsp_sess_ff;
   logic [LOSS_W-1:0]    rsp_loss_ff;
   logic [RTT_W-1:0]     rsp_rtt_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic                 out_free;
   logic                 accept;

   assign count_dec  = count_ff - CNT_W'(1);
   assign last_idx   = count_dec[IDX_W-1:0];
   assign scan_issue = (scan_ff < count_ff);
   assign hit        = cmp_valid_ff && (key_q == key_ff);
   assign full       = (count_ff >= CNT_W'(TABLE_DEPTH));
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_command == CMD_ADD && req_node_key == '0) ? S_DONE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit || !scan_issue) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = (found_ff && cmd_ff != CMD_ADD) ? S_MODIFY : S_DONE;
         end
         S_MODIFY: state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memory control and counters
   always_comb begin
      req_ready    = 1'b0;
      key_rd_addr  = '0;
      data_rd_addr = '0;
      key_we       = 1'b0;
      key_wa       = hit_idx_ff;
      key_wd       = key_q;
      data_we      = 1'b0;
      data_wa      = hit_idx_ff;
      data_wd      = data_q;
      count_in     = count_ff;
      scan_in      = scan_ff;
      cmp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            scan_in   = '0;
         end
         S_SCAN: begin
            key_rd_addr  = scan_ff[IDX_W-1:0];
            cmp_valid_in = scan_issue && !hit;
            if (scan_issue) begin
               scan_in = scan_ff + CNT_W'(1);
            end
         end
         S_READ: begin
            key_rd_addr  = last_idx;
            data_rd_addr = (cmd_ff == CMD_REMOVE) ? last_idx : hit_idx_ff;
            if (cmd_ff == CMD_ADD) begin
               data_wd = '{session: sess_ff, loss: '0, rtt: '0};
               if (found_ff) begin
                  data_we = 1'b1;
               end else if (!full) begin
                  key_we   = 1'b1;
                  key_wa   = count_ff[IDX_W-1:0];
                  key_wd   = key_ff;
                  data_we  = 1'b1;
                  data_wa  = count_ff[IDX_W-1:0];
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         S_MODIFY: begin
            case (cmd_ff)
               CMD_REMOVE: begin
                  key_we   = 1'b1;
                  data_we  = 1'b1;
                  count_in = count_dec;
               end
               CMD_UPDATE: begin
                  data_we = 1'b1;
                  data_wd = '{session: data_q.session,
                              loss:    blend_loss(data_q.loss, loss_ff),
                              rtt:     blend_rtt(data_q.rtt, rtt_ff)};
               end
               default: ;
            endcase
         end
         S_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      key_q  <= key_mem[key_rd_addr];
      data_q <= data_mem[data_rd_addr];
      if (key_we) begin
         key_mem[key_wa] <= key_wd;
      end
      if (data_we) begin
         data_mem[data_wa] <= data_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         cmp_valid_ff <= cmp_valid_in;
         if (state_ff == S_IDLE) begin
            found_ff <= 1'b0;
         end else if (state_ff == S_SCAN && hit) begin
            found_ff <= 1'b1;
         end
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= scan_ff[IDX_W-1:0];
      if (accept) begin
         cmd_ff      <= req_command;
         key_ff      <= req_node_key;
         sess_ff     <= req_session_value;
         loss_ff     <= req_loss_sample;
         rtt_ff      <= req_rtt_sample;
         res_sess_ff <= '0;
         res_loss_ff <= '0;
         res_rtt_ff  <= '0;
         res_status_ff <= (req_command == CMD_ADD && req_node_key == '0) ?
                          STAT_BAD_KEY : STAT_NOT_FOUND;
      end
      if (state_ff == S_SCAN && hit) begin
         hit_idx_ff <= cmp_idx_ff;
      end
      if (state_ff == S_READ) begin
         if (cmd_ff == CMD_ADD) begin
            res_status_ff <= found_ff ? STAT_REFRESHED : (full ? STAT_FULL : STAT_INSERTED);
         end else if (found_ff) begin
            res_status_ff <= STAT_DONE;
         end
      end
      if (state_ff == S_MODIFY && cmd_ff == CMD_FIND) begin
         res_sess_ff <= data_q.session;
         res_loss_ff <= data_q.loss;
         res_rtt_ff  <= data_q.rtt;
      end
      if (state_ff == S_DONE && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_sess_ff   <= res_sess_ff;
         rsp_loss_ff   <= res_loss_ff;
         rsp_rtt_ff    <= res_rtt_ff;
         rsp_count_ff  <= COUNT_W'(count_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_hit_session = rsp_sess_ff;
   assign rsp_hit_loss    = rsp_loss_ff;
   assign rsp_hit_rtt     = rsp_rtt_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// ===== rtl/rtewma_checker.sv =====
// ----------------------------------------------------------------------------
// rtewma_checker
// Port-level checks for the route table, bound to the top level.
// ----------------------------------------------------------------------------
module rtewma_checker
   import rtewma_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [CMD_W-1:0]     req_command,
   input logic [KEY_W-1:0]     req_node_key,
   input logic [SESSION_W-1:0] req_session_value,
   input logic [LOSS_W-1:0]    req_loss_sample,
   input logic [RTT_W-1:0]     req_rtt_sample,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [STATUS_W-1:0]  rsp_status,
   input logic [SESSION_W-1:0] rsp_hit_session,
   input logic [LOSS_W-1:0]    rsp_hit_loss,
   input logic [RTT_W-1:0]     rsp_hit_rtt,
   input logic [COUNT_W-1:0]   rsp_entry_count
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_hit_session) && $stable(rsp_entry_count))
      else $error("stalled result beat changed");

   a_hit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_DONE |->
      rsp_hit_session == '0 && rsp_hit_loss == '0 && rsp_hit_rtt == '0)
      else $error("hit fields nonzero without a hit");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_entry_count) <= TABLE_DEPTH &&
      (rsp_status == STAT_INSERTED || rsp_status == STAT_REFRESHED ||
       rsp_status == STAT_DONE || rsp_status == STAT_NOT_FOUND ||
       rsp_status == STAT_FULL || rsp_status == STAT_BAD_KEY))
      else $error("entry count or status out of range");

endmodule

bind route_table_with_ewma_metrics rtewma_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (.*);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the node-keyed route table with smoothed metrics.
// A behavioral copy of the table predicts each reply when a request beat is
// accepted. The expected replies are checked in order against the DUT.
// Directed tests cover the bad key, the empty table, the full table,
// refresh and swap-with-last removal. Random traffic then runs through
// three backpressure phases.
// ----------------------------------------------------------------------------
module testbench
   import rtewma_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH          = 64;
   localparam int KEY_POOL_SIZE  = 80;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 80;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [SESSION_W-1:0] session;
      logic [LOSS_W-1:0]    loss;
      logic [RTT_W-1:0]     rtt;
      logic [COUNT_W-1:0]   entry_count;
   } route_reply_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_command = CMD_ADD;
   logic [KEY_W-1:0]     req_node_key = '0;
   logic [SESSION_W-1:0] req_session_value = '0;
   logic [LOSS_W-1:0]    req_loss_sample = '0;
   logic [RTT_W-1:0]     req_rtt_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [SESSION_W-1:0] rsp_hit_session;
   logic [LOSS_W-1:0]    rsp_hit_loss;
   logic [RTT_W-1:0]     rsp_hit_rtt;
   logic [COUNT_W-1:0]   rsp_entry_count;

   // shadow copy of the table
   logic [KEY_W-1:0]     table_keys     [DEPTH];
   logic [SESSION_W-1:0] table_sessions [DEPTH];
   logic [LOSS_W-1:0]    table_loss     [DEPTH];
   logic [RTT_W-1:0]     table_rtt      [DEPTH];
   int unsigned          table_used = 0;

   logic [KEY_W-1:0]     key_pool [KEY_POOL_SIZE];
   route_reply_type      route_replies_due [$];
   route_reply_type      due_reply;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count   = 0;
   int stall_cycles  = 0;
   int replies_checked = 0;
   int cmd_seen    [4] = '{default: 0};
   int status_seen [8] = '{default: 0};

   route_table_with_ewma_metrics #(
      .TABLE_DEPTH(DEPTH)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_node_key      (req_node_key),
      .req_session_value (req_session_value),
      .req_loss_sample   (req_loss_sample),
      .req_rtt_sample    (req_rtt_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_hit_session   (rsp_hit_session),
      .rsp_hit_loss      (rsp_hit_loss),
      .rsp_hit_rtt       (rsp_hit_rtt),
      .rsp_entry_count   (rsp_entry_count)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] random_word64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [KEY_W-1:0] random_node_key();
      logic [KEY_W-1:0] key;
      do key = random_word64(); while (key == '0);
      return key;
   endfunction

   function automatic int lookup_slot(input logic [KEY_W-1:0] key);
      if (key == '0) return -1;
      for (int i = 0; i < int'(table_used); i++) begin
         if (table_keys[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic logic [63:0] smooth_metric(input logic [63:0] old_value,
                                                 input logic [63:0] sample);
      if (old_value == '0) return sample;
      return (old_value * 64'd7 + sample) >> 3;
   endfunction

   task automatic apply_route_command(input logic [CMD_W-1:0] cmd,
                                      input logic [KEY_W-1:0] key,
                                      input logic [SESSION_W-1:0] session,
                                      input logic [LOSS_W-1:0] loss,
                                      input logic [RTT_W-1:0] rtt,
                                      output route_reply_type reply);
      int slot;
      int unsigned last;
      logic [63:0] blended;
      reply = '0;
      reply.status = STAT_NOT_FOUND;
      slot = lookup_slot(key);
      if (cmd == CMD_ADD) begin
         if (key == '0) begin
            reply.status = STAT_BAD_KEY;
         end else if (slot >= 0) begin
            table_sessions[slot] = session;
            table_loss[slot] = '0;
            table_rtt[slot] = '0;
            reply.status = STAT_REFRESHED;
         end else if (table_used >= DEPTH) begin
            reply.status = STAT_FULL;
         end else begin
            table_keys[table_used] = key;
            table_sessions[table_used] = session;
            table_loss[table_used] = '0;
            table_rtt[table_used] = '0;
            table_used++;
            reply.status = STAT_INSERTED;
         end
      end else if (slot >= 0) begin
         reply.status = STAT_DONE;
         case (cmd)
            CMD_REMOVE: begin
               last = table_used - 1;
               table_keys[slot] = table_keys[last];
               table_sessions[slot] = table_sessions[last];
               table_loss[slot] = table_loss[last];
               table_rtt[slot] = table_rtt[last];
               table_used = last;
            end
            CMD_FIND: begin
               reply.session = table_sessions[slot];
               reply.loss = table_loss[slot];
               reply.rtt = table_rtt[slot];
            end
            default: begin
               blended = smooth_metric(table_loss[slot], loss);
               table_loss[slot] = blended[LOSS_W-1:0];
               blended = smooth_metric(table_rtt[slot], rtt);
               table_rtt[slot] = blended[RTT_W-1:0];
            end
         endcase
      end
      reply.entry_count = COUNT_W'(table_used);
   endtask

   task automatic send_request(input logic [CMD_W-1:0] cmd,
                               input logic [KEY_W-1:0] key,
                               input logic [SESSION_W-1:0] session,
                               input logic [LOSS_W-1:0] loss,
                               input logic [RTT_W-1:0] rtt);
      route_reply_type reply;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_node_key <= key;
      req_session_value <= session;
      req_loss_sample <= loss;
      req_rtt_sample <= rtt;
      do @(posedge clock); while (!req_ready);
      apply_route_command(cmd, key, session, loss, rtt, reply);
      route_replies_due.push_back(reply);
      cmd_seen[cmd]++;
   endtask

   task automatic wait_for_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (route_replies_due.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [63:0] expected,
                              input logic [63:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, expected, actual);
         error_count++;
      end
   endtask

   // receiver backpressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_status <= STAT_BAD_KEY) status_seen[rsp_status]++;
         if (route_replies_due.size() == 0) begin
            $display("%0t: unexpected reply beat, expected none, actual status %0d",
                     $time, rsp_status);
            error_count++;
         end else begin
            due_reply = route_replies_due.pop_front();
            replies_checked++;
            check_field("status", due_reply.status, rsp_status);
            check_field("hit_session", due_reply.session, rsp_hit_session);
            check_field("hit_loss", due_reply.loss, rsp_hit_loss);
            check_field("hit_rtt", due_reply.rtt, rsp_hit_rtt);
            check_field("entry_count", due_reply.entry_count, rsp_entry_count);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d replies outstanding",
                     $time, stall_cycles, route_replies_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic test_empty_table();
      logic [KEY_W-1:0] absent_key;
      absent_key = random_node_key();
      send_request(CMD_ADD, '0, random_word64(), '1, '1);
      send_request(CMD_REMOVE, '0, '0, '0, '0);
      send_request(CMD_FIND, '0, '0, '0, '0);
      send_request(CMD_UPDATE, '0, '0, '1, '1);
      send_request(CMD_FIND, absent_key, '1, '0, '0);
      send_request(CMD_REMOVE, absent_key, '0, '0, '0);
      send_request(CMD_UPDATE, absent_key, '0, '1, '1);
   endtask

   task automatic test_entry_lifecycle();
      logic [KEY_W-1:0] key_hi;
      logic [KEY_W-1:0] key_lo;
      key_hi = '1;
      key_lo = 64'd1;
      send_request(CMD_ADD, key_hi, '1, '1, '1);
      send_request(CMD_ADD, key_lo, '0, '0, '0);
      send_request(CMD_ADD, '0, '1, '0, '0);
      send_request(CMD_FIND, key_hi, '0, '0, '0);
      // first sample is taken as is, later ones are blended
      send_request(CMD_UPDATE, key_hi, '0, '1, '1);
      send_request(CMD_UPDATE, key_hi, '0, '0, '0);
      send_request(CMD_UPDATE, key_hi, '0, '1, '1);
      send_request(CMD_FIND, key_hi, '0, '0, '0);
      send_request(CMD_UPDATE, key_lo, '0, '0, '0);
      wait_for_replies();
      send_request(CMD_ADD, key_hi, random_word64(), '1, '1);
      send_request(CMD_FIND, key_hi, '0, '0, '0);
      // slot 0 removed: last entry moves down
      send_request(CMD_REMOVE, key_hi, '0, '0, '0);
      send_request(CMD_FIND, key_lo, '0, '0, '0);
      send_request(CMD_FIND, key_hi, '0, '0, '0);
      send_request(CMD_UPDATE, key_hi, '0, '1, '1);
      send_request(CMD_REMOVE, key_lo, '0, '0, '0);
      send_request(CMD_REMOVE, key_lo, '0, '0, '0);
   endtask

   task automatic test_full_table();
      logic [KEY_W-1:0] key;
      while (table_used < DEPTH) begin
         send_request(CMD_ADD, random_node_key(), random_word64(), '0, '0);
      end
      send_request(CMD_ADD, random_node_key(), random_word64(), '0, '0);
      send_request(CMD_ADD, '0, random_word64(), '0, '0);
      key = table_keys[$urandom_range(DEPTH - 1)];
      send_request(CMD_UPDATE, key, '0, 16'($urandom), 40'(random_word64()));
      send_request(CMD_ADD, key, random_word64(), '0, '0);
      send_request(CMD_FIND, key, '0, '0, '0);
      send_request(CMD_FIND, table_keys[DEPTH - 1], '0, '0, '0);
      key = table_keys[DEPTH - 1];
      send_request(CMD_REMOVE, table_keys[0], '0, '0, '0);
      send_request(CMD_FIND, key, '0, '0, '0);
      while (table_used > 0) begin
         key = table_keys[$urandom_range(table_used - 1)];
         if ($urandom_range(3) == 0) begin
            send_request(CMD_UPDATE, key, '0, 16'($urandom), 40'(random_word64()));
            send_request(CMD_FIND, key, '0, '0, '0);
         end
         send_request(CMD_REMOVE, key, '0, '0, '0);
      end
   endtask

   task automatic test_random_traffic(input int unsigned beats);
      logic [CMD_W-1:0]     cmd;
      logic [KEY_W-1:0]     key;
      logic [SESSION_W-1:0] session;
      logic [LOSS_W-1:0]    loss;
      logic [RTT_W-1:0]     rtt;
      int unsigned          pick;
      repeat (beats) begin
         pick = $urandom_range(99);
         if (pick < 35) cmd = CMD_ADD;
         else if (pick < 55) cmd = CMD_REMOVE;
         else if (pick < 75) cmd = CMD_FIND;
         else cmd = CMD_UPDATE;
         pick = $urandom_range(99);
         if (pick < 3) key = '0;
         else if (pick < 8) key = random_node_key();
         else if (pick < 40 || table_used == 0) key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
         else key = table_keys[$urandom_range(table_used - 1)];
         session = ($urandom_range(15) == 0) ? '0 : random_word64();
         case ($urandom_range(9))
            0: begin
               loss = '0;
               rtt = '0;
            end
            1: begin
               loss = '1;
               rtt = '1;
            end
            2: begin
               loss = 16'($urandom_range(255));
               rtt = 40'($urandom_range(100000));
            end
            default: begin
               loss = 16'($urandom);
               rtt = 40'(random_word64());
            end
         endcase
         if ($urandom_range(199) == 0) wait_for_replies();
         send_request(cmd, key, session, loss, rtt);
      end
   endtask

   initial begin
      for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = random_node_key();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 33;
      recv_idle_pct = 71;
      test_empty_table();
      test_entry_lifecycle();
      test_full_table();
      test_random_traffic(350);

      send_idle_pct = 71;
      recv_idle_pct = 33;
      test_random_traffic(500);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_full_table();
      test_random_traffic(450);

      wait_for_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d replies: %0d add, %0d remove, %0d find, %0d update requests",
               replies_checked, cmd_seen[CMD_ADD], cmd_seen[CMD_REMOVE],
               cmd_seen[CMD_FIND], cmd_seen[CMD_UPDATE]);
      $display("Statuses: %0d inserted, %0d refreshed, %0d done, %0d not found, %s",
               status_seen[STAT_INSERTED], status_seen[STAT_REFRESHED],
               status_seen[STAT_DONE], status_seen[STAT_NOT_FOUND],
               $sformatf("%0d full, %0d bad key",
                         status_seen[STAT_FULL], status_seen[STAT_BAD_KEY]));
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
